>>> rtl/monotonic_cputime_split_core_macros.svh
// Assertion macros shared by the monotonic CPU time split block
`ifndef MONOTONIC_CPUTIME_SPLIT_CORE_MACROS_SVH
`define MONOTONIC_CPUTIME_SPLIT_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcs_pkg.sv
// Types and constants of the monotonic CPU time split block
package mcs_pkg;

    localparam int TIME_BITS = 64;
    localparam int HALF_BITS = 32;
    localparam int PROD_BITS = 2 * HALF_BITS;

    typedef struct packed {
        logic [TIME_BITS-1:0] in_stime;
        logic [TIME_BITS-1:0] in_utime;
        logic [TIME_BITS-1:0] run_time;
    } t_in_beat;

    typedef struct packed {
        logic [TIME_BITS-1:0] out_utime;
        logic [TIME_BITS-1:0] out_stime;
    } t_out_beat;

endpackage

>>> rtl/mcs_in_if.sv
// Input channel: valid/ready handshake carrying one sample beat
interface mcs_in_if import mcs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mcs_out_if.sv
// Output channel: valid/ready handshake carrying one adjusted time beat
interface mcs_out_if import mcs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/monotonic_cputime_split_core.sv
// Monotonic CPU time split: top level with sequencer, clamps and output register
//
// i_in carries one beat of system ticks, user ticks and total runtime; o_out
// returns one beat of adjusted user and system time for every input beat.
// Values are taken modulo 2^TIME_WIDTH and returned zero-extended to 64 bits.
// One beat is in flight at a time; i_in.ready is high only while idle.
// From acceptance the sequencer passes check and finish when the runtime has
// not grown, and check, clamp, user subtract and finish when a tick count is
// zero. A full split adds normalization passes (one per cycle), then the
// serial multiplier, which retires one bit per cycle, and the divider, which
// retires one quotient bit, ahead of the clamp.
// A zero divisor after normalization skips both.
// The next beat is accepted from idle, entered as its predecessor's result loads.
// The result sits in an output register; the next beat is accepted while it
// waits, and the sequencer holds its next result until o_out is free.
// Reset clears the stored user/system pair to zero and empties the output.
`include "monotonic_cputime_split_core_macros.svh"
module monotonic_cputime_split_core import mcs_pkg::*; #(
    parameter int TIME_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mcs_in_if.sink    i_in,
    mcs_out_if.source o_out
);

    localparam int W = TIME_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_NORM  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_CLAMP = 8'b0010_0000,
        S_USUB  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state       r_state;
    t_state       n_state;
    logic [W-1:0] r_sti;
    logic [W-1:0] r_uti;
    logic [W-1:0] r_rt;
    logic [W-1:0] r_tot;
    logic [W-1:0] r_st;
    logic [W-1:0] r_ut;
    logic [W-1:0] r_prev_s;
    logic [W-1:0] r_prev_u;
    logic         r_upd;
    logic         r_ovalid;
    t_out_beat    r_odata;

    logic                 in_acc;
    logic                 out_free;
    logic [W-1:0]         prev_sum;
    logic                 grow;
    logic [W-1:0]         ut_diff;
    logic                 norm_go;
    logic                 norm_done;
    logic [HALF_BITS-1:0] norm_s;
    logic [HALF_BITS-1:0] norm_r;
    logic [HALF_BITS-1:0] norm_tot;
    logic                 mul_go;
    logic                 mul_done;
    logic [PROD_BITS-1:0] mul_prod;
    logic                 div_go;
    logic                 div_done;
    logic [PROD_BITS-1:0] div_quo;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign prev_sum = r_prev_s + r_prev_u;
    assign grow     = prev_sum < r_rt;
    assign ut_diff  = r_rt - r_st;

    assign norm_go = (r_state == S_CHECK) && grow && (r_sti != '0) && (r_uti != '0);
    assign mul_go  = (r_state == S_NORM) && norm_done && (norm_tot != '0);
    assign div_go  = (r_state == S_MUL) && mul_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!grow) n_state = S_FIN;
                else if (norm_go) n_state = S_NORM;
                else n_state = S_CLAMP;
            end
            S_NORM: begin
                if (norm_done) n_state = (norm_tot != '0) ? S_MUL : S_CLAMP;
            end
            S_MUL: begin
                if (mul_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_CLAMP;
            end
            S_CLAMP: n_state = S_USUB;
            S_USUB:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev_s <= '0;
            r_prev_u <= '0;
            r_upd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHECK) r_upd <= grow;
            if ((r_state == S_FIN) && out_free) begin
                r_ovalid <= 1'b1;
                if (r_upd) begin
                    r_prev_s <= r_st;
                    r_prev_u <= r_ut;
                end
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sti <= i_in.data.in_stime[W-1:0];
            r_uti <= i_in.data.in_utime[W-1:0];
            r_rt  <= i_in.data.run_time[W-1:0];
            r_tot <= i_in.data.in_stime[W-1:0] + i_in.data.in_utime[W-1:0];
        end
        case (r_state)
            S_CHECK: begin
                r_st <= (r_sti == '0) ? '0 : r_rt;
            end
            S_NORM: begin
                if (norm_done && (norm_tot == '0)) r_st <= '1;
            end
            S_DIV: begin
                if (div_done) r_st <= div_quo[W-1:0];
            end
            S_CLAMP: begin
                if (r_st < r_prev_s) r_st <= r_prev_s;
            end
            S_USUB: begin
                if (ut_diff < r_prev_u) begin
                    r_ut <= r_prev_u;
                    r_st <= r_rt - r_prev_u;
                end else begin
                    r_ut <= ut_diff;
                end
            end
            default: begin
            end
        endcase
        if ((r_state == S_FIN) && out_free) begin
            r_odata.out_utime <= TIME_BITS'(r_upd ? r_ut : r_prev_u);
            r_odata.out_stime <= TIME_BITS'(r_upd ? r_st : r_prev_s);
        end
    end

    mcs_norm #(
        .W (W)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_go),
        .i_s     (r_sti),
        .i_r     (r_rt),
        .i_tot   (r_tot),
        .o_done  (norm_done),
        .o_s     (norm_s),
        .o_r     (norm_r),
        .o_tot   (norm_tot)
    );

    mcs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (norm_s),
        .i_b     (norm_r),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (mul_prod),
        .i_divisor  (norm_tot),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    `MCS_ASSERT_NEXT(a_accept_to_check, in_acc, r_state == S_CHECK, "beat accepted but no check")
    `MCS_ASSERT_NOW(a_norm_done_state, norm_done, r_state == S_NORM, "normalizer done out of turn")
    `MCS_ASSERT_NOW(a_div_done_state, div_done, r_state == S_DIV, "divider done out of turn")
    `MCS_ASSERT_NEXT(a_fin_loads_out, (r_state == S_FIN) && out_free, r_ovalid && (r_state == S_IDLE), "result not loaded")

endmodule

>>> rtl/mcs_norm.sv
// Operand normalizer: one swap/shift iteration per cycle down to 32-bit operands
module mcs_norm import mcs_pkg::*; #(
    parameter int W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_s,
    input  logic [W-1:0]         i_r,
    input  logic [W-1:0]         i_tot,
    output logic                 o_done,
    output logic [HALF_BITS-1:0] o_s,
    output logic [HALF_BITS-1:0] o_r,
    output logic [HALF_BITS-1:0] o_tot
);

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_s;
    logic [W-1:0] r_r;
    logic [W-1:0] r_tot;

    logic         swap;
    logic [W-1:0] s1;
    logic [W-1:0] r1;
    logic         tot_hi;
    logic         r_hi;
    logic         s_hi;

    always_comb begin
        swap   = r_s > r_r;
        s1     = swap ? r_r : r_s;
        r1     = swap ? r_s : r_r;
        tot_hi = |r_tot[W-1:HALF_BITS];
        r_hi   = |r1[W-1:HALF_BITS];
        s_hi   = |s1[W-1:HALF_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !tot_hi && !r_hi) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s   <= i_s;
            r_r   <= i_r;
            r_tot <= i_tot;
        end else if (r_busy) begin
            if (tot_hi || (r_hi && s_hi)) begin
                r_s   <= s1;
                r_r   <= r1 >> 1;
                r_tot <= r_tot >> 1;
            end else if (r_hi) begin
                r_s <= s1 << 1;
                r_r <= r1 >> 1;
            end else begin
                r_s <= s1;
                r_r <= r1;
            end
        end
    end

    assign o_done = r_done;
    assign o_s    = r_s[HALF_BITS-1:0];
    assign o_r    = r_r[HALF_BITS-1:0];
    assign o_tot  = r_tot[HALF_BITS-1:0];

endmodule

>>> rtl/mcs_mul.sv
// Serial 32x32 multiplier: one multiplier bit per cycle, shift-add
module mcs_mul import mcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [HALF_BITS-1:0] i_a,
    input  logic [HALF_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [PROD_BITS-1:0] o_prod
);

    localparam int CNT_W = $clog2(HALF_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [HALF_BITS-1:0] r_a;
    logic [HALF_BITS-1:0] r_hi;
    logic [HALF_BITS-1:0] r_lo;
    logic [HALF_BITS:0]   sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(HALF_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[HALF_BITS:1];
            r_lo <= {sum[0], r_lo[HALF_BITS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

>>> rtl/mcs_div.sv
// Serial 64/32 restoring divider: one quotient bit per cycle
module mcs_div import mcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PROD_BITS-1:0] i_dividend,
    input  logic [HALF_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [PROD_BITS-1:0] o_quo
);

    localparam int CNT_W = $clog2(PROD_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [HALF_BITS-1:0] r_rem;
    logic [HALF_BITS-1:0] r_dvs;
    logic [PROD_BITS-1:0] r_quo;
    logic [HALF_BITS:0]   trial;
    logic [HALF_BITS:0]   diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem, r_quo[PROD_BITS-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[HALF_BITS-1:0] : trial[HALF_BITS-1:0];
            r_quo <= {r_quo[PROD_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
